### hw/rtl/lsbse_pkg.sv
// lsbse_pkg: shared types, operation codes and register indexes
// for the lsb stego engine; no dependencies
`default_nettype none
package lsbse_pkg;

	localparam int MAX_PIXELS_DEF = 65536;
	localparam int LIM_W          = 25;

	localparam logic [2:0] FUNC_LOAD    = 3'd0;
	localparam logic [2:0] FUNC_RESTART = 3'd1;
	localparam logic [2:0] FUNC_EMBED   = 3'd2;
	localparam logic [2:0] FUNC_EXTRACT = 3'd3;
	localparam logic [2:0] FUNC_READ    = 3'd4;

	localparam logic [2:0] OP_LOAD    = 3'd0;
	localparam logic [2:0] OP_RESTART = 3'd1;
	localparam logic [2:0] OP_EMBED   = 3'd2;
	localparam logic [2:0] OP_EXTRACT = 3'd3;
	localparam logic [2:0] OP_READ    = 3'd4;
	localparam logic [2:0] OP_NONE    = 3'd5;

	localparam logic [2:0] REG_STEP     = 3'd0;
	localparam logic [2:0] REG_BPP      = 3'd1;
	localparam logic [2:0] REG_CHANNELS = 3'd2;
	localparam logic [2:0] REG_BPB      = 3'd3;
	localparam logic [2:0] REG_COUNT    = 3'd4;

	localparam logic [31:0] STEP_RST     = 32'h0001_0000;
	localparam logic [5:0]  BPP_RST      = 6'd3;
	localparam logic [2:0]  CHANNELS_RST = 3'd3;
	localparam logic [3:0]  BPB_RST      = 4'd8;
	localparam logic [16:0] COUNT_RST    = 17'h1_0000;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] pixel_addr;
		logic [31:0] pixel_value;
		logic [7:0]  data_byte;
	} item_t;

	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctl_t;

endpackage
`default_nettype wire

### hw/rtl/lsbse_front.sv
// lsbse_front: request intake, decodes func into an operation code
// depends on lsbse_pkg
`default_nettype none
module lsbse_front (
	input  wire logic               tvalid,
	output logic                    tready,
	input  wire logic [55:0]        tdata,
	input  wire logic [7:0]         tuser,
	input  wire logic               full,
	output logic                    push,
	output lsbse_pkg::item_t        item
);

	logic [2:0] op;

	always_comb begin
		unique case (tuser[2:0])
			lsbse_pkg::FUNC_LOAD:    op = lsbse_pkg::OP_LOAD;
			lsbse_pkg::FUNC_RESTART: op = lsbse_pkg::OP_RESTART;
			lsbse_pkg::FUNC_EMBED:   op = lsbse_pkg::OP_EMBED;
			lsbse_pkg::FUNC_EXTRACT: op = lsbse_pkg::OP_EXTRACT;
			lsbse_pkg::FUNC_READ:    op = lsbse_pkg::OP_READ;
			default:                 op = lsbse_pkg::OP_NONE;
		endcase
	end

	assign tready           = !full;
	assign push             = tvalid && !full;
	assign item.op          = op;
	assign item.pixel_addr  = tdata[15:0];
	assign item.pixel_value = tdata[47:16];
	assign item.data_byte   = tdata[55:48];

endmodule
`default_nettype wire

### hw/rtl/lsbse_queue.sv
// lsbse_queue: two-entry request queue between intake and execution
// depends on lsbse_pkg
`default_nettype none
module lsbse_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lsbse_pkg::queue_ctl_t ctl,
	input  wire lsbse_pkg::item_t     wr_item,
	output lsbse_pkg::item_t          rd_item,
	output logic                      full,
	output logic                      empty
);

	lsbse_pkg::item_t slot_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign rd_item = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			slot_q[wptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (ctl.push) wptr_q <= !wptr_q;
			if (ctl.pop)  rptr_q <= !rptr_q;
			count_q <= count_q + {1'b0, ctl.push} - {1'b0, ctl.pop};
		end
	end

endmodule
`default_nettype wire

### hw/rtl/lsbse_back.sv
// lsbse_back: pixel memory, carrier sequencer and result register
// depends on lsbse_pkg
`default_nettype none
module lsbse_back #(
	parameter int MAX_PIXELS = lsbse_pkg::MAX_PIXELS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [2:0]       wr_index,
	input  wire logic [31:0]      wr_data,
	input  wire lsbse_pkg::item_t head,
	input  wire logic             empty,
	output logic                  pop,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output logic [7:0]            res_data,
	output logic [31:0]           res_pixel,
	output logic                  res_status
);

	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int LW = lsbse_pkg::LIM_W;
	localparam logic [LW-1:0] MAXP = LW'(MAX_PIXELS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_BIT   = 3'd1;
	localparam logic [2:0] ST_FWAIT = 3'd2;
	localparam logic [2:0] ST_DONE  = 3'd3;

	logic [31:0] mem [MAX_PIXELS];
	logic [31:0] rdata_q;
	logic        mem_we;
	logic        mem_re;
	logic [AW-1:0] mem_addr;
	logic [31:0] mem_wdata;

	logic [31:0] step_q;
	logic [5:0]  bpp_q;
	logic [2:0]  chan_q;
	logic [3:0]  bpb_q;
	logic [16:0] count_q;

	logic [2:0]  state_q;
	logic [2:0]  op_q;
	logic [7:0]  dat_q;
	logic [3:0]  bt_q;
	logic [7:0]  dout_q;
	logic        rd_ok_q;
	logic [31:0] cur_q;
	logic [5:0]  bits_q;
	logic [1:0]  ch_q;
	logic [3:0]  plane_q;
	logic [32:0] pos_q;
	logic        ovf_q;
	logic        dirty_q;
	logic        need_q;
	logic        res_valid_q;
	logic [7:0]  res_data_q;
	logic [31:0] res_pixel_q;
	logic        res_status_q;

	logic [2:0]    eff_ch;
	logic [LW-1:0] lim;
	logic          car_ok;
	logic          head_ok;
	logic [4:0]    sel;
	logic          plane_ok;
	logic          in_bit;
	logic [31:0]   new_cur;
	logic          ex_bit;
	logic          ch_wrap;
	logic [5:0]    bits_nx;
	logic          complete;
	logic [32:0]   pos_nx;
	logic          ovf_hit;
	logic          last_bit;

	always_comb begin
		if (chan_q == 3'd0)     eff_ch = 3'd1;
		else if (chan_q > 3'd4) eff_ch = 3'd4;
		else                    eff_ch = chan_q;
		lim      = ({8'd0, count_q} > MAXP) ? MAXP : {8'd0, count_q};
		car_ok   = {8'd0, pos_q[32:16]} < MAXP;
		head_ok  = {9'd0, head.pixel_addr} < MAXP;
		sel      = {ch_q, plane_q[2:0]};
		plane_ok = !plane_q[3];
		in_bit   = bt_q[3] ? 1'b0 : dat_q[bt_q[2:0]];
		new_cur  = cur_q;
		if (plane_ok) new_cur[sel] = in_bit;
		ex_bit   = plane_ok & cur_q[sel];
		ch_wrap  = ({1'b0, ch_q} + 3'd1) >= eff_ch;
		bits_nx  = bits_q + 6'd1;
		complete = bits_nx >= bpp_q;
		pos_nx   = pos_q + {1'b0, step_q};
		ovf_hit  = {8'd0, pos_nx[32:16]} >= lim;
		last_bit = ({1'b0, bt_q} + 5'd1) >= {1'b0, bpb_q};
	end

	assign pop = (state_q == ST_IDLE) && !empty && !res_valid_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = AW'(pos_q[32:16]);
		mem_wdata = cur_q;
		unique case (state_q)
			ST_IDLE: begin
				mem_addr  = AW'(head.pixel_addr);
				mem_wdata = head.pixel_value;
				mem_we    = pop && head_ok && (head.op == lsbse_pkg::OP_LOAD);
				mem_re    = pop && head_ok && (head.op == lsbse_pkg::OP_READ);
			end
			ST_BIT: begin
				mem_re    = need_q && car_ok;
				mem_we    = !need_q && car_ok && complete &&
					(op_q == lsbse_pkg::OP_EMBED);
				mem_wdata = new_cur;
			end
			ST_DONE: begin
				mem_we = (op_q == lsbse_pkg::OP_EMBED) && dirty_q && car_ok;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= lsbse_pkg::STEP_RST;
			bpp_q   <= lsbse_pkg::BPP_RST;
			chan_q  <= lsbse_pkg::CHANNELS_RST;
			bpb_q   <= lsbse_pkg::BPB_RST;
			count_q <= lsbse_pkg::COUNT_RST;
		end else if (wr_en) begin
			case (wr_index)
				lsbse_pkg::REG_STEP:     step_q  <= wr_data;
				lsbse_pkg::REG_BPP:      bpp_q   <= wr_data[5:0];
				lsbse_pkg::REG_CHANNELS: chan_q  <= wr_data[2:0];
				lsbse_pkg::REG_BPB:      bpb_q   <= wr_data[3:0];
				lsbse_pkg::REG_COUNT:    count_q <= wr_data[16:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q    <= head.op;
			dat_q   <= head.data_byte;
			rd_ok_q <= head_ok;
		end
		if (state_q == ST_DONE) begin
			res_data_q   <= (op_q == lsbse_pkg::OP_EXTRACT) ? dout_q : 8'd0;
			res_pixel_q  <= ((op_q == lsbse_pkg::OP_READ) && rd_ok_q) ? rdata_q : 32'd0;
			res_status_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bt_q        <= 4'd0;
			dout_q      <= 8'd0;
			cur_q       <= 32'd0;
			bits_q      <= 6'd0;
			ch_q        <= 2'd0;
			plane_q     <= 4'd0;
			pos_q       <= 33'd0;
			ovf_q       <= 1'b0;
			dirty_q     <= 1'b0;
			need_q      <= 1'b1;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready) res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						bt_q    <= 4'd0;
						dout_q  <= 8'd0;
						state_q <= ST_DONE;
						if (head.op == lsbse_pkg::OP_RESTART) begin
							pos_q   <= 33'd0;
							need_q  <= 1'b1;
							bits_q  <= 6'd0;
							ch_q    <= 2'd0;
							plane_q <= 4'd0;
							ovf_q   <= 1'b0;
							dirty_q <= 1'b0;
						end else if (((head.op == lsbse_pkg::OP_EMBED) ||
							(head.op == lsbse_pkg::OP_EXTRACT)) &&
							!ovf_q && (bpb_q != 4'd0)) begin
							state_q <= ST_BIT;
						end
					end
				end
				ST_BIT: begin
					if (need_q) begin
						state_q <= ST_FWAIT;
					end else begin
						if (op_q == lsbse_pkg::OP_EMBED) begin
							cur_q   <= new_cur;
							dirty_q <= !complete;
						end
						if (!bt_q[3] && ex_bit) dout_q[bt_q[2:0]] <= 1'b1;
						if (ch_wrap) begin
							ch_q <= 2'd0;
							if (plane_ok) plane_q <= plane_q + 4'd1;
						end else begin
							ch_q <= ch_q + 2'd1;
						end
						bits_q <= bits_nx;
						bt_q   <= bt_q + 4'd1;
						if (complete) begin
							need_q <= 1'b1;
							pos_q  <= pos_nx;
							if (ovf_hit) ovf_q <= 1'b1;
						end
						if (last_bit || (complete && ovf_hit)) state_q <= ST_DONE;
					end
				end
				ST_FWAIT: begin
					cur_q   <= car_ok ? rdata_q : 32'd0;
					bits_q  <= 6'd0;
					ch_q    <= 2'd0;
					plane_q <= 4'd0;
					need_q  <= 1'b0;
					state_q <= ST_BIT;
				end
				ST_DONE: begin
					dirty_q     <= 1'b0;
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid  = res_valid_q;
	assign res_data   = res_data_q;
	assign res_pixel  = res_pixel_q;
	assign res_status = res_status_q;

	a_done_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |=> res_valid_q)
		else $error("finished request produced no result");
	a_one_port_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("memory read and write in one cycle");
	a_ovf_needs_load: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> need_q)
		else $error("overflow with a live carrier");
	a_plane_range: assert property (@(posedge clk) disable iff (!arst_n)
		plane_q <= 4'd8)
		else $error("bit plane past eight");

endmodule
`default_nettype wire

### hw/rtl/lsb_stego_embed_extract.sv
// LSB stego engine over an RGBA pixel memory with a single-port array.
// Load, read, restart and unknown codes pass from the head of the queue
// straight to the done state; embed and extract step through the bit state,
// with a carrier fetch and fetch wait for every carrier pixel, and the one
// memory port serves fetch, write-back, load and read. Results leave through a
// registered output while up to two further requests wait in the queue.
// top level: lsb_stego_embed_extract; depends on lsbse_pkg, lsbse_front,
// lsbse_queue, lsbse_back
`default_nettype none
module lsb_stego_embed_extract #(
	parameter int MAX_PIXELS = lsbse_pkg::MAX_PIXELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [31:0] wr_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [55:0] s_axis_tdata,  // pixel_addr, pixel_value, data_byte
	input  wire logic [7:0]  s_axis_tuser,  // func
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata   // data_out, pixel_out, status
);

	lsbse_pkg::item_t      in_item;
	lsbse_pkg::item_t      head_item;
	lsbse_pkg::queue_ctl_t qctl;
	logic                  q_full;
	logic                  q_empty;
	logic                  push;
	logic                  pop;
	logic [7:0]            res_data;
	logic [31:0]           res_pixel;
	logic                  res_status;

	assign qctl.push = push;
	assign qctl.pop  = pop;

	lsbse_front u_front (
		.tvalid (s_axis_tvalid),
		.tready (s_axis_tready),
		.tdata  (s_axis_tdata),
		.tuser  (s_axis_tuser),
		.full   (q_full),
		.push   (push),
		.item   (in_item)
	);

	lsbse_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (qctl),
		.wr_item (in_item),
		.rd_item (head_item),
		.full    (q_full),
		.empty   (q_empty)
	);

	lsbse_back #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.head       (head_item),
		.empty      (q_empty),
		.pop        (pop),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res_data   (res_data),
		.res_pixel  (res_pixel),
		.res_status (res_status)
	);

	assign m_axis_tdata = {7'd0, res_status, res_pixel, res_data};

endmodule
`default_nettype wire

### tb/testbench.sv
// testbench for lsb_stego_embed_extract: random and directed requests over the
// stream ports, results checked against an in-bench model of the pixel memory
// depends on lsbse_pkg and the block's rtl
`timescale 1ns / 100ps
`default_nettype none
module testbench;

	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] addr;
		logic [31:0] pval;
		logic [7:0]  dbyte;
	} req_t;

	// same layout as m_axis_tdata[40:0], lowest field last
	typedef struct packed {
		logic        ovf;
		logic [31:0] pout;
		logic [7:0]  dout;
	} rsp_t;

	localparam int NPIX = 65536;
	localparam int WATCH_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [2:0] wr_index = '0;
	logic [31:0] wr_data = '0;
	logic s_axis_tvalid = 1'b0;
	wire s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic [7:0] s_axis_tuser = '0;
	wire m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	wire [47:0] m_axis_tdata;

	always #6 clk = ~clk;

	lsb_stego_embed_extract dut (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// model state
	logic [31:0] img [NPIX];
	logic [31:0] carrier;
	int unsigned fill_bits, chan, plane;
	bit need_fetch, ovf, dirty;
	logic [32:0] pos;
	logic [31:0] step_cfg;
	logic [5:0] bpp_cfg;
	logic [2:0] chan_cfg;
	logic [3:0] bpb_cfg;
	logic [16:0] count_cfg;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int errors = 0;
	int accepted_reqs = 0;
	int idle_cycles = 0;
	bit hold_off = 1'b0;
	bit sender_hold = 1'b0;
	int burst_left = 0, gap_left = 0;

	function automatic int unsigned eff_chan();
		if (chan_cfg == 0) return 1;
		if (chan_cfg > 4) return 4;
		return chan_cfg;
	endfunction

	function automatic logic [32:0] pos_limit();
		logic [32:0] pc;
		pc = (count_cfg > NPIX) ? NPIX : count_cfg;
		return pc << 16;
	endfunction

	function automatic logic [31:0] mem_rd(logic [32:0] a);
		return (a < NPIX) ? img[a[15:0]] : 32'h0;
	endfunction

	function automatic void mem_wr(logic [32:0] a, logic [31:0] v);
		if (a < NPIX) img[a[15:0]] = v;
	endfunction

	function automatic void fetch();
		if (need_fetch) begin
			carrier = mem_rd(pos >> 16);
			fill_bits = 0;
			chan = 0;
			plane = 0;
			need_fetch = 0;
		end
	endfunction

	function automatic bit step_bit(bit wb);
		chan++;
		if (chan >= eff_chan()) begin
			chan = 0;
			if (plane < 8) plane++;
		end
		fill_bits = (fill_bits + 1) & 6'h3f;
		if (fill_bits >= bpp_cfg) begin
			if (wb) begin
				mem_wr(pos >> 16, carrier);
				dirty = 0;
			end
			need_fetch = 1;
			pos = pos + {1'b0, step_cfg};
			if (pos >= pos_limit()) begin
				ovf = 1;
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic rsp_t stego_predict(req_t r);
		rsp_t o;
		logic [7:0] d;
		logic [7:0] lane;
		logic [7:0] msk;
		o = '0;
		d = r.dbyte;
		case (r.func)
			lsbse_pkg::FUNC_LOAD: mem_wr(r.addr, r.pval);
			lsbse_pkg::FUNC_RESTART: begin
				pos = 0; need_fetch = 1; fill_bits = 0; chan = 0; plane = 0;
				ovf = 0; dirty = 0;
			end
			lsbse_pkg::FUNC_EMBED: if (!ovf) begin
				for (int b = 0; b < bpb_cfg; b++) begin
					fetch();
					if (plane < 8) begin
						lane = carrier[chan*8 +: 8];
						msk = ~(8'h1 << plane);
						lane = (lane & msk) | (8'(d[0]) << plane);
						carrier[chan*8 +: 8] = lane;
					end
					d = d >> 1;
					dirty = 1;
					if (step_bit(1)) break;
				end
				if (dirty) begin
					mem_wr(pos >> 16, carrier);
					dirty = 0;
				end
			end
			lsbse_pkg::FUNC_EXTRACT: if (!ovf) begin
				for (int b = 0; b < bpb_cfg; b++) begin
					logic bitv;
					bitv = 0;
					fetch();
					if (plane < 8) bitv = carrier[chan*8 + plane];
					if (b < 8) o.dout[b] = bitv;
					if (step_bit(0)) break;
				end
			end
			lsbse_pkg::FUNC_READ: o.pout = mem_rd(r.addr);
			default: ;
		endcase
		o.ovf = ovf;
		return o;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_rsps.push_back(stego_predict(pending_reqs.pop_front()));
				accepted_reqs++;
			end
			if (s_axis_tvalid && !(s_axis_tready)) begin
				// keep offering
			end else if (pending_reqs.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0)
					&& !sender_hold && burst_left > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {pending_reqs[0].dbyte, pending_reqs[0].pval,
					pending_reqs[0].addr};
				s_axis_tuser <= {5'd0, pending_reqs[0].func};
				burst_left--;
			end else begin
				s_axis_tvalid <= 1'b0;
				if (gap_left > 0) gap_left--;
				else begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
				end
			end
		end
	end

	// monitor
	int stall_phase = 0;
	always @(posedge clk) begin
		rsp_t got, want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[40:0];
				if (expected_rsps.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result %h", got);
				end else begin
					want = expected_rsps.pop_front();
					if (got !== want || m_axis_tdata[47:41] !== '0) begin
						errors++;
						if (errors <= 10)
							$display({"mismatch: data exp %h got %h, pixel exp %h got %h,",
								" status exp %b got %b"},
								want.dout, got.dout, want.pout, got.pout, want.ovf, got.ovf);
					end
				end
			end
			stall_phase = (stall_phase + 1) % 23;
			m_axis_tready <= !hold_off && (stall_phase < 11 ? 1'b1 : ($urandom_range(0, 2) != 0));
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_off)
			idle_cycles <= 0;
		else if (pending_reqs.size() > 0 || expected_rsps.size() > 0) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WATCH_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic push_req(logic [2:0] f, logic [15:0] a, logic [31:0] v, logic [7:0] d);
		req_t r;
		r.func = f; r.addr = a; r.pval = v; r.dbyte = d;
		pending_reqs.push_back(r);
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic set_reg(logic [2:0] idx, logic [31:0] v);
		@(posedge clk);
		wr_en <= 1'b1; wr_index <= idx; wr_data <= v;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			lsbse_pkg::REG_STEP: step_cfg = v;
			lsbse_pkg::REG_BPP: bpp_cfg = v[5:0];
			lsbse_pkg::REG_CHANNELS: chan_cfg = v[2:0];
			lsbse_pkg::REG_BPB: bpb_cfg = v[3:0];
			lsbse_pkg::REG_COUNT: count_cfg = v[16:0];
			default: ;
		endcase
	endtask

	// load a small image, then restart so carriers are all written pixels
	task automatic load_image(int n);
		for (int i = 0; i < n; i++) push_req(lsbse_pkg::FUNC_LOAD, i[15:0], $urandom, '0);
		push_req(lsbse_pkg::FUNC_RESTART, $urandom, $urandom, $urandom);
	endtask

	task automatic random_traffic(int n, int img_n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 35) push_req(lsbse_pkg::FUNC_EMBED, $urandom, $urandom, $urandom);
			else if (k < 65) push_req(lsbse_pkg::FUNC_EXTRACT, $urandom, $urandom, $urandom);
			else if (k < 73) push_req(lsbse_pkg::FUNC_RESTART, $urandom, $urandom, $urandom);
			else if (k < 83) push_req(lsbse_pkg::FUNC_LOAD, $urandom_range(0, img_n - 1),
				$urandom, $urandom);
			else if (k < 95) push_req(lsbse_pkg::FUNC_READ, $urandom_range(0, img_n - 1),
				$urandom, $urandom);
			else push_req(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		carrier = 0; fill_bits = 0; chan = 0; plane = 0; need_fetch = 1; ovf = 0;
		dirty = 0; pos = 0;
		step_cfg = lsbse_pkg::STEP_RST; bpp_cfg = lsbse_pkg::BPP_RST;
		chan_cfg = lsbse_pkg::CHANNELS_RST;
		bpb_cfg = lsbse_pkg::BPB_RST; count_cfg = lsbse_pkg::COUNT_RST;
		foreach (img[i]) img[i] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed, default config, 64 pixels with all image bits exercised
		set_reg(lsbse_pkg::REG_COUNT, 17'd64);
		load_image(64);
		push_req(lsbse_pkg::FUNC_LOAD, 16'hffff, 32'hffff_ffff, 8'h00);
		push_req(lsbse_pkg::FUNC_READ, 16'hffff, 32'h0, 8'hff);
		push_req(lsbse_pkg::FUNC_EMBED, 0, 0, 8'hff);
		push_req(lsbse_pkg::FUNC_EMBED, 0, 32'hffff_ffff, 8'h00);
		push_req(lsbse_pkg::FUNC_EMBED, 0, 0, 8'ha5);
		push_req(lsbse_pkg::FUNC_RESTART, 0, 0, 0);
		push_req(lsbse_pkg::FUNC_EXTRACT, 0, 0, 0);
		push_req(lsbse_pkg::FUNC_EXTRACT, 0, 0, 0);
		push_req(lsbse_pkg::FUNC_EXTRACT, 0, 0, 0);
		push_req(lsbse_pkg::FUNC_READ, 0, 0, 0);
		push_req(lsbse_pkg::FUNC_LOAD, 1, 32'h1234_5678, 0);
		push_req(3'd5, 16'hffff, 32'hffff_ffff, 8'hff);
		push_req(3'd7, 0, 0, 0);
		drain();

		// overflow: tiny image, huge step
		set_reg(lsbse_pkg::REG_STEP, 32'hffff_ffff);
		set_reg(lsbse_pkg::REG_COUNT, 17'd1);
		set_reg(lsbse_pkg::REG_BPP, 6'd0);
		push_req(lsbse_pkg::FUNC_RESTART, 0, 0, 0);
		push_req(lsbse_pkg::FUNC_EMBED, 0, 0, 8'h3c);
		push_req(lsbse_pkg::FUNC_EXTRACT, 0, 0, 0);
		push_req(lsbse_pkg::FUNC_RESTART, 0, 0, 0);
		push_req(lsbse_pkg::FUNC_EXTRACT, 0, 0, 0);
		push_req(lsbse_pkg::FUNC_READ, 0, 0, 0);
		drain();

		// deep planes, out-of-range channel and byte widths
		set_reg(lsbse_pkg::REG_STEP, 32'h0001_0000);
		set_reg(lsbse_pkg::REG_COUNT, 17'd64);
		set_reg(lsbse_pkg::REG_BPP, 6'd32);
		set_reg(lsbse_pkg::REG_CHANNELS, 3'd0);
		set_reg(lsbse_pkg::REG_BPB, 4'd15);
		push_req(lsbse_pkg::FUNC_RESTART, 0, 0, 0);
		for (int i = 0; i < 4; i++) push_req(lsbse_pkg::FUNC_EMBED, 0, 0, $urandom);
		push_req(lsbse_pkg::FUNC_RESTART, 0, 0, 0);
		for (int i = 0; i < 4; i++) push_req(lsbse_pkg::FUNC_EXTRACT, 0, 0, 0);
		drain();

		// random phases over several settings
		for (int ph = 0; ph < 8; ph++) begin
			int img_n;
			img_n = (ph == 7) ? 65536 : $urandom_range(8, 64);
			set_reg(lsbse_pkg::REG_STEP, (ph == 0) ? 32'h0001_0000 :
				(ph == 1) ? 32'h0004_8000 : $urandom_range(32'h1_0000, 32'h3_ffff));
			set_reg(lsbse_pkg::REG_BPP, (ph == 2) ? 6'd63 : (ph == 3) ? 6'd1 :
				6'($urandom_range(1, 32)));
			set_reg(lsbse_pkg::REG_CHANNELS, (ph == 4) ? 3'd7 : 3'($urandom_range(1, 4)));
			set_reg(lsbse_pkg::REG_BPB, (ph == 5) ? 4'd1 : (ph == 6) ? 4'd12 :
				4'($urandom_range(1, 8)));
			set_reg(lsbse_pkg::REG_COUNT, (ph == 7) ? 17'h1_0000 : 17'(img_n));
			if (ph == 7) begin
				// whole memory already loaded only where written; keep to 64 pixels
				img_n = 64;
				set_reg(lsbse_pkg::REG_COUNT, 17'd64);
			end
			load_image(img_n);
			if (ph == 3) begin
				drain();
				hold_off = 1'b1;
			end
			random_traffic(80, img_n);
			if (ph == 3) begin
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			if (ph == 5) begin
				drain();
				sender_hold = 1'b1;
				repeat (20) @(posedge clk);
				sender_hold = 1'b0;
			end
			drain();
		end

		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
`default_nettype wire
